### rtl/core/jse_pkg.sv
`timescale 1ns / 1ps

package jse_pkg;

	localparam int MAX_OUT = 7;
	localparam int CNT_W = 3;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A = 8'h61;

	// one input's worth of output bytes, lowest index first
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        count;
		logic                    closing;
	} res_t;

endpackage

### rtl/core/jse_front.sv
`timescale 1ns / 1ps

module jse_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    in_byte,
	input  logic          source_is_utf8,
	output logic          push,
	output jse_pkg::res_t res
);

	logic       open_q, mode_q;
	logic [1:0] held_q, need_q;
	logic [7:0] pend_q [0:2];

	logic       open_n, mode_n;
	logic [1:0] held_n, need_n, need_c;
	logic       wr_en;
	logic [1:0] wr_idx;
	logic [jse_pkg::MAX_OUT-1:0][7:0] ob;
	logic [jse_pkg::CNT_W-1:0] n;
	logic       closing;
	logic [7:0] esc;

	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h08: r = 8'h62;
			8'h0a: r = 8'h6e;
			8'h0d: r = 8'h72;
			8'h0c: r = 8'h66;
			8'h09: r = 8'h74;
			jse_pkg::CH_QUOTE: r = jse_pkg::CH_QUOTE;
			jse_pkg::CH_BSLASH: r = jse_pkg::CH_BSLASH;
			jse_pkg::CH_SLASH: r = jse_pkg::CH_SLASH;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = jse_pkg::CH_ZERO + {4'd0, v};
		end else begin
			r = jse_pkg::CH_A + {4'd0, v} - 8'd10;
		end
		return r;
	endfunction

	assign esc = escape_letter(in_byte);

	always_comb begin
		if (in_byte[7:4] == 4'hf) begin
			need_c = 2'd3;
		end else if (in_byte[7:4] == 4'he) begin
			need_c = 2'd2;
		end else if (in_byte[7:5] == 3'b110) begin
			need_c = 2'd1;
		end else begin
			need_c = 2'd0;
		end
	end

	always_comb begin
		ob = '0;
		n = '0;
		closing = 1'b0;
		open_n = open_q;
		mode_n = mode_q;
		held_n = held_q;
		need_n = need_q;
		wr_en = 1'b0;
		wr_idx = 2'd0;
		if (!open_q) begin
			ob[n] = jse_pkg::CH_QUOTE;
			n = n + 3'd1;
			open_n = 1'b1;
			mode_n = source_is_utf8;
			held_n = 2'd0;
			need_n = 2'd0;
		end
		if (in_byte == 8'h00) begin
			ob[n] = jse_pkg::CH_QUOTE;
			n = n + 3'd1;
			closing = 1'b1;
			open_n = 1'b0;
			held_n = 2'd0;
			need_n = 2'd0;
		end else if (need_n != 2'd0) begin
			if (held_n >= need_n) begin
				for (int i = 0; i < 3; i++) begin
					if (i < int'(held_n)) begin
						ob[n] = pend_q[i];
						n = n + 3'd1;
					end
				end
				ob[n] = in_byte;
				n = n + 3'd1;
				held_n = 2'd0;
				need_n = 2'd0;
			end else begin
				wr_en = 1'b1;
				wr_idx = held_n;
				held_n = held_n + 2'd1;
			end
		end else if (esc != 8'h00) begin
			ob[n] = jse_pkg::CH_BSLASH;
			n = n + 3'd1;
			ob[n] = esc;
			n = n + 3'd1;
		end else if (in_byte < 8'd32) begin
			ob[n] = jse_pkg::CH_BSLASH;
			n = n + 3'd1;
			ob[n] = jse_pkg::CH_U;
			n = n + 3'd1;
			ob[n] = jse_pkg::CH_ZERO;
			n = n + 3'd1;
			ob[n] = jse_pkg::CH_ZERO;
			n = n + 3'd1;
			ob[n] = hex_digit(in_byte[7:4]);
			n = n + 3'd1;
			ob[n] = hex_digit(in_byte[3:0]);
			n = n + 3'd1;
		end else if (mode_n) begin
			if (need_c != 2'd0) begin
				wr_en = 1'b1;
				wr_idx = 2'd0;
				held_n = 2'd1;
				need_n = need_c;
			end else begin
				ob[n] = in_byte;
				n = n + 3'd1;
			end
		end else if (in_byte[7]) begin
			ob[n] = {6'b110000, in_byte[7:6]};
			n = n + 3'd1;
			ob[n] = {2'b10, in_byte[5:0]};
			n = n + 3'd1;
		end else begin
			ob[n] = in_byte;
			n = n + 3'd1;
		end
	end

	assign res.bytes = ob;
	assign res.count = n;
	assign res.closing = closing;
	assign push = accept && (n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			mode_q <= 1'b0;
			held_q <= 2'd0;
			need_q <= 2'd0;
		end else if (accept) begin
			open_q <= open_n;
			mode_q <= mode_n;
			held_q <= held_n;
			need_q <= need_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			case (wr_idx)
				2'd0: pend_q[0] <= in_byte;
				2'd1: pend_q[1] <= in_byte;
				2'd2: pend_q[2] <= in_byte;
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/jse_queue.sv
`timescale 1ns / 1ps

module jse_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jse_pkg::res_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          rd_valid,
	output jse_pkg::res_t rd_data
);

	jse_pkg::res_t mem_q [0:1];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;

	assign full = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### rtl/core/jse_back.sv
`timescale 1ns / 1ps

module jse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  jse_pkg::res_t q_data,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast,
	output logic [0:0]    m_tuser
);

	logic                      valid_q;
	jse_pkg::res_t             entry_q;
	logic [jse_pkg::CNT_W-1:0] idx_q;
	logic                      last;
	logic                      advance;

	assign last = (idx_q == entry_q.count - 3'd1);
	assign advance = !valid_q || (m_tready && last);
	assign pop = q_valid && advance;

	assign m_tvalid = valid_q;
	assign m_tdata = entry_q.bytes[idx_q];
	assign m_tlast = last;
	assign m_tuser = last && entry_q.closing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (advance) begin
			valid_q <= q_valid;
			idx_q <= '0;
		end else if (m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= q_data;
		end
	end

endmodule

### rtl/core/json_string_escaper.sv
`timescale 1ns / 1ps

// Quotes and escapes a zero-terminated byte string for JSON. The input side takes one byte per
// cycle while the two-entry result queue has room; each accepted byte is classified at once and
// its whole expansion (zero to seven bytes) is queued. The output side sends one byte per cycle
// while m_tready is high. An input byte expands to one output byte for plain text, two for
// short escapes and Latin-1 upper bytes, six for \u00xx, up to four when a buffered UTF-8
// sequence completes, plus one for the opening quote of each string. Bytes that only extend a
// pending UTF-8 sequence produce nothing. Each expansion is registered in the result queue and
// then in the output stage before its first byte is sent.
module json_string_escaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // in_byte
	input  logic [0:0] s_tuser,  // source_is_utf8
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic       m_tlast,  // run_end
	output logic [0:0] m_tuser   // string_end
);

	logic          accept, push, full, pop, q_valid;
	jse_pkg::res_t res, q_data;

	assign s_tready = !full;
	assign accept = s_tvalid && s_tready;

	jse_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.in_byte        (s_tdata),
		.source_is_utf8 (s_tuser[0]),
		.push           (push),
		.res            (res)
	);

	jse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (res),
		.full     (full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_data  (q_data)
	);

	jse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

### dv/jse_checker.sv
`timescale 1ns / 1ps

module jse_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,  // in_byte
	input  logic [0:0] s_tuser,  // source_is_utf8
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,  // out_byte
	input  logic       m_tlast,  // run_end
	input  logic [0:0] m_tuser,  // string_end
	output int         errors,
	output int         outstanding,
	output int         checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       str_end;
	} json_char_t;

	json_char_t json_q[$];

	logic       str_open;
	logic       utf8_mode;
	logic [7:0] seq_buf[3];
	int         seq_held;
	int         seq_need;
	int         err_cnt = 0;
	int         seen_cnt = 0;

	function automatic logic [7:0] short_escape(input logic [7:0] c);
		case (c)
			8'h08: return 8'h62;
			8'h0a: return 8'h6e;
			8'h0d: return 8'h72;
			8'h0c: return 8'h66;
			8'h09: return 8'h74;
			jse_pkg::CH_QUOTE: return jse_pkg::CH_QUOTE;
			jse_pkg::CH_BSLASH: return jse_pkg::CH_BSLASH;
			jse_pkg::CH_SLASH: return jse_pkg::CH_SLASH;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? jse_pkg::CH_ZERO + 8'(n) : jse_pkg::CH_A + 8'(n) - 8'd10;
	endfunction

	// expansion of one source byte into json bytes
	task automatic escape_byte(input logic [7:0] b, input logic u);
		logic [7:0] chunk[$];
		logic       closing;
		int         need;
		int         i;
		closing = 1'b0;
		if (!str_open) begin
			chunk.push_back(jse_pkg::CH_QUOTE);
			str_open = 1'b1;
			utf8_mode = u;
			seq_held = 0;
			seq_need = 0;
		end
		if (b == 8'h00) begin
			chunk.push_back(jse_pkg::CH_QUOTE);
			closing = 1'b1;
			str_open = 1'b0;
			seq_held = 0;
			seq_need = 0;
		end else if (seq_need != 0) begin
			if (seq_held >= seq_need) begin
				for (i = 0; i < seq_held; i++)
					chunk.push_back(seq_buf[i]);
				chunk.push_back(b);
				seq_held = 0;
				seq_need = 0;
			end else begin
				seq_buf[seq_held] = b;
				seq_held++;
			end
		end else if (short_escape(b) != 8'h00) begin
			chunk.push_back(jse_pkg::CH_BSLASH);
			chunk.push_back(short_escape(b));
		end else if (b < 8'd32) begin
			chunk.push_back(jse_pkg::CH_BSLASH);
			chunk.push_back(jse_pkg::CH_U);
			chunk.push_back(jse_pkg::CH_ZERO);
			chunk.push_back(jse_pkg::CH_ZERO);
			chunk.push_back(hex_char(b[7:4]));
			chunk.push_back(hex_char(b[3:0]));
		end else if (utf8_mode) begin
			if (b[7:4] == 4'hf)
				need = 3;
			else if (b[7:4] == 4'he)
				need = 2;
			else if (b[7:5] == 3'b110)
				need = 1;
			else
				need = 0;
			if (need != 0) begin
				seq_buf[0] = b;
				seq_held = 1;
				seq_need = need;
			end else begin
				chunk.push_back(b);
			end
		end else if (b[7]) begin
			chunk.push_back({6'b110000, b[7:6]});
			chunk.push_back({2'b10, b[5:0]});
		end else begin
			chunk.push_back(b);
		end
		for (i = 0; i < chunk.size(); i++)
			json_q.push_back('{chunk[i], i == chunk.size() - 1,
				(i == chunk.size() - 1) && closing});
	endtask

	always @(posedge clk or negedge arst_n) begin
		json_char_t want;
		if (!arst_n) begin
			str_open = 1'b0;
			utf8_mode = 1'b0;
			seq_held = 0;
			seq_need = 0;
			json_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				escape_byte(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready) begin
				seen_cnt++;
				if (json_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected transaction: data %h last %b end %b",
							m_tdata, m_tlast, m_tuser[0]);
				end else begin
					want = json_q.pop_front();
					if (m_tdata !== want.data || m_tlast !== want.last ||
						m_tuser[0] !== want.str_end) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: data %h/%h last %b/%b end %b/%b (exp/act)",
								want.data, m_tdata, want.last, m_tlast,
								want.str_end, m_tuser[0]);
					end
				end
			end
		end
		outstanding <= json_q.size();
		errors <= err_cnt;
		checked <= seen_cnt;
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG = 1000;
	localparam int HOLD_CYCLES = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata = 8'h00;  // in_byte
	logic [0:0] s_tuser = 1'b0;   // source_is_utf8
	logic       m_tready = 1'b0;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;          // out_byte
	logic       m_tlast;          // run_end
	logic [0:0] m_tuser;          // string_end

	int errors;
	int outstanding;
	int checked;
	int quiet = 0;
	int items_sent = 0;
	int strings_sent = 0;
	int utf8_strings = 0;
	bit str_mode = 1'b0;
	bit str_fresh = 1'b1;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	logic [7:0] esc_chars[8] = '{8'h08, 8'h0a, 8'h0d, 8'h0c, 8'h09, 8'h22, 8'h5c, 8'h2f};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	json_string_escaper u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	jse_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.errors     (errors),
		.outstanding(outstanding),
		.checked    (checked)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG);
			$display("tb_top failed");
			$finish;
		end
	end

	// mode is only honoured on the first byte of a string, later bytes carry noise
	task automatic put_byte(input logic [7:0] b);
		int   gap;
		logic u;
		u = str_fresh ? str_mode : 1'($urandom_range(0, 1));
		if (str_fresh && str_mode)
			utf8_strings++;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= u;
		do @(posedge clk); while (!s_tready);
		str_fresh = (b == 8'h00);
		items_sent++;
		if (b == 8'h00)
			strings_sent++;
	endtask

	task automatic random_string();
		int len;
		int k;
		int j;
		int kind;
		int ncont;
		str_mode = 1'($urandom_range(0, 1));
		len = $urandom_range(0, 10);
		for (k = 0; k < len; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35)
				put_byte(8'($urandom_range(8'h20, 8'h7e)));
			else if (kind < 50)
				put_byte(esc_chars[$urandom_range(0, 7)]);
			else if (kind < 60)
				put_byte(8'($urandom_range(1, 31)));
			else if (!str_mode)
				put_byte(8'($urandom_range(8'h80, 8'hff)));
			else if (kind < 68)
				put_byte(8'($urandom_range(8'h80, 8'hbf)));
			else begin
				ncont = $urandom_range(1, 3);
				case (ncont)
					1: put_byte(8'($urandom_range(8'hc0, 8'hdf)));
					2: put_byte(8'($urandom_range(8'he0, 8'hef)));
					default: put_byte(8'($urandom_range(8'hf0, 8'hff)));
				endcase
				for (j = 0; j < ncont; j++) begin
					if ($urandom_range(0, 11) == 0) begin
						put_byte(8'h00);
						return;
					end
					if ($urandom_range(0, 7) == 0)
						put_byte(8'($urandom_range(1, 255)));
					else
						put_byte(8'($urandom_range(8'h80, 8'hbf)));
				end
			end
		end
		put_byte(8'h00);
	endtask

	initial begin
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string
		str_mode = 1'b1;
		put_byte(8'h00);
		// latin-1: every short escape, control codes, upper bytes
		str_mode = 1'b0;
		foreach (esc_chars[i])
			if (i == 0)
				put_byte(8'h01);
		foreach (esc_chars[i])
			put_byte(esc_chars[i]);
		put_byte(8'h1f);
		put_byte(8'hff);
		put_byte(8'h80);
		put_byte(8'h00);
		// utf-8: two-byte, quote and control inside a sequence, 0xf8 lead, stray, cut short
		str_mode = 1'b1;
		put_byte(8'hc3);
		put_byte(8'ha9);
		put_byte(8'he2);
		put_byte(8'h22);
		put_byte(8'h01);
		put_byte(8'hf8);
		put_byte(8'h80);
		put_byte(8'h80);
		put_byte(8'h80);
		put_byte(8'h90);
		put_byte(8'he0);
		put_byte(8'h00);

		// long receiver hold-off while the sender keeps offering
		no_idle = 1'b1;
		hold_req = 1'b1;
		for (n = 0; n < 5; n++)
			random_string();
		while (items_sent < 240) begin
			no_idle = ($urandom_range(0, 3) == 0);
			random_string();
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d bytes in %0d strings (%0d utf-8), checked %0d output bytes",
			items_sent, strings_sent, utf8_strings, checked);
		$display("%0d mismatches", errors);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		int stall;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!no_idle) begin
				stall = $urandom_range(0, 19);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

endmodule

### filelist.f
rtl/core/jse_pkg.sv
rtl/core/jse_front.sv
rtl/core/jse_queue.sv
rtl/core/jse_back.sv
rtl/core/json_string_escaper.sv
dv/jse_checker.sv
dv/tb_top.sv
